// ===== rtl/bgcd_pkg.sv =====
package bgcd_pkg;

  localparam int DEF_WINDOW_LENGTH    = 50;
  localparam int DEF_RIGHT_BAND_START = 1043;

  localparam int GRID_ROWS = 6;
  localparam int GRID_COLS = 7;

  localparam logic [31:0] BAND_MARK_LOW  = 32'd214;
  localparam logic [31:0] BAND_MARK_HIGH = 32'd214 << 8;

  localparam logic signed [11:0] NOT_FOUND_TL = 12'sd1000;
  localparam logic signed [11:0] NOT_FOUND_BR = -12'sd1;

  // Reciprocal constants for truncating division of a 12-bit magnitude by 12 and 14.
  localparam int          DIV_SHIFT  = 15;
  localparam logic [11:0] DIV12_MULT = 12'd2731;
  localparam logic [11:0] DIV14_MULT = 12'd2341;

  typedef logic [2:0] cfg_index_t;

  localparam cfg_index_t REG_DETECT_MODE      = 3'd0;
  localparam cfg_index_t REG_FRAME_WIDTH      = 3'd1;
  localparam cfg_index_t REG_FRAME_HEIGHT     = 3'd2;
  localparam cfg_index_t REG_DARK_THRESHOLD   = 3'd3;
  localparam cfg_index_t REG_WHITE_FLOOR      = 3'd4;
  localparam cfg_index_t REG_MARKER_SPLIT_ROW = 3'd5;

  typedef enum logic [1:0] {
    COLOUR_WHITE = 2'd0,
    COLOUR_GREEN = 2'd1,
    COLOUR_RED   = 2'd2
  } cell_colour_t;

  typedef logic signed [11:0] coord_t;

  typedef struct packed {
    coord_t top_row;
    coord_t left_col;
    coord_t bottom_row;
    coord_t right_col;
  } corners_t;

  typedef logic [GRID_ROWS-1:0][10:0] row_centres_t;
  typedef logic [GRID_COLS-1:0][10:0] col_centres_t;

  typedef struct packed {
    logic       push;
    logic       clear;
    logic [9:0] bright;
  } win_req_t;

  typedef struct packed {
    logic        full;
    logic [15:0] sum;
  } win_stat_t;

endpackage

// ===== rtl/bgcd_window.sv =====
module bgcd_window #(
  parameter int WINDOW_LENGTH = bgcd_pkg::DEF_WINDOW_LENGTH
) (
  input  logic                clk,
  input  logic                rst,
  input  bgcd_pkg::win_req_t  req,
  output bgcd_pkg::win_stat_t stat
);
  import bgcd_pkg::*;

  localparam int PW = $clog2(WINDOW_LENGTH);
  localparam logic [PW-1:0] LAST = PW'(WINDOW_LENGTH - 1);

  logic [9:0]    store [WINDOW_LENGTH];
  logic [9:0]    rd_data;
  logic [PW-1:0] pos, pos_next, pos_eff, wp, rd_addr;
  logic          full, full_next, full_eff, full_new;
  logic [15:0]   sum, sum_next, sum_eff, sum_sub, sum_new;

  always_comb begin
    pos_eff  = req.clear ? LAST : pos;
    full_eff = req.clear ? 1'b0 : full;
    sum_eff  = req.clear ? 16'd0 : sum;
    wp       = (pos_eff == LAST) ? '0 : pos_eff + 1'b1;
    // rd_data already holds the entry about to be overwritten.
    sum_sub  = full_eff ? sum_eff - {6'd0, rd_data} : sum_eff;
    sum_new  = sum_sub + {6'd0, req.bright};
    full_new = full_eff | (wp == LAST);
    pos_next  = req.push ? wp : pos_eff;
    full_next = req.push ? full_new : full_eff;
    sum_next  = req.push ? sum_new : sum_eff;
    // Fetch the entry the following beat will replace.
    rd_addr  = (pos_next == LAST) ? '0 : pos_next + 1'b1;
  end

  assign stat.full = full_new;
  assign stat.sum  = sum_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= LAST;
      full <= 1'b0;
      sum  <= 16'd0;
    end else begin
      pos  <= pos_next;
      full <= full_next;
      sum  <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req.push) begin
      store[wp] <= req.bright;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= store[rd_addr];
  end

endmodule

// ===== rtl/bgcd_centres.sv =====
module bgcd_centres (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  bgcd_pkg::corners_t     corners,
  output bgcd_pkg::row_centres_t centre_rows,
  output bgcd_pkg::col_centres_t centre_cols,
  output logic                   busy
);
  import bgcd_pkg::*;

  logic              pend, step_valid;
  logic signed [12:0] dy_diff, dx_diff;
  logic [11:0]       dy_mag, dx_mag;
  logic [23:0]       dy_prod, dx_prod;
  logic [8:0]        dy_quot, dx_quot;
  logic [7:0]        dy_step, dx_step, dy, dx;
  logic [10:0]       base_row, base_col;
  row_centres_t      rows_next;
  col_centres_t      cols_next;

  always_comb begin
    dy_diff = {corners.bottom_row[11], corners.bottom_row}
            - {corners.top_row[11], corners.top_row};
    dx_diff = {corners.right_col[11], corners.right_col}
            - {corners.left_col[11], corners.left_col};
    dy_mag  = dy_diff[12] ? 12'(-dy_diff) : dy_diff[11:0];
    dx_mag  = dx_diff[12] ? 12'(-dx_diff) : dx_diff[11:0];
    dy_prod = dy_mag * DIV12_MULT;
    dx_prod = dx_mag * DIV14_MULT;
    dy_quot = dy_prod[DIV_SHIFT +: 9];
    dx_quot = dx_prod[DIV_SHIFT +: 9];
    // Quotients truncate toward zero, so the sign goes back on afterwards.
    dy_step = dy_diff[12] ? 8'(-dy_quot) : dy_quot[7:0];
    dx_step = dx_diff[12] ? 8'(-dx_quot) : dx_quot[7:0];
  end

  always_comb begin
    for (int k = 0; k < GRID_ROWS; k++) begin
      rows_next[k] = 11'({3'd0, dy} * 11'(2 * k + 1)) + base_row;
    end
    for (int k = 0; k < GRID_COLS; k++) begin
      cols_next[k] = 11'({3'd0, dx} * 11'(2 * k + 1)) + base_col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend        <= 1'b0;
      step_valid  <= 1'b0;
      centre_rows <= '0;
      centre_cols <= '0;
    end else begin
      pend       <= start;
      step_valid <= pend;
      if (step_valid) begin
        centre_rows <= rows_next;
        centre_cols <= cols_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend) begin
      dy       <= dy_step;
      dx       <= dx_step;
      base_row <= corners.top_row[10:0];
      base_col <= corners.left_col[10:0];
    end
  end

  assign busy = pend | step_valid;

endmodule

// ===== rtl/board_grid_corner_and_colour_detector_core.sv =====
// A pixel accepted into the input register has its result registered in the output registers.
// Throughput: one pixel per clock while result_ready does not hold the output. After the last
// pixel of a corner-mode frame the core holds while the centres are found from the corners.
// Reset (synchronous, active high) restores the configuration, counters, corners and grid;
// the window memory is not cleared, since entries are only read once written in the frame.
module board_grid_corner_and_colour_detector_core #(
  parameter int WINDOW_LENGTH    = bgcd_pkg::DEF_WINDOW_LENGTH,
  parameter int RIGHT_BAND_START = bgcd_pkg::DEF_RIGHT_BAND_START
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   pixel_valid,
  output logic                   pixel_ready,
  input  logic [31:0]            pixel_word,
  output logic                   result_valid,
  input  logic                   result_ready,
  output logic [31:0]            out_pixel,
  output logic                   frame_done,
  output logic [10:0]            top_row,
  output logic signed [11:0]     left_col,
  output logic signed [11:0]     bottom_row,
  output logic signed [11:0]     right_col,
  output logic                   colour_valid,
  output logic [5:0]             cell_index,
  output bgcd_pkg::cell_colour_t cell_colour,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  bgcd_pkg::cfg_index_t   cfg_index,
  input  logic [15:0]            cfg_data
);
  import bgcd_pkg::*;

  // Configuration
  logic        detect_mode;
  logic [10:0] frame_width, frame_height, marker_split_row;
  logic [15:0] dark_threshold;
  logic [7:0]  white_floor;

  // Input register
  logic        s1_valid;
  logic [31:0] s1_pixel;

  // Frame state
  logic [10:0] row_count, col_count, row_next, col_next;
  logic        lower_half, lower_next;
  corners_t    corners, corners_eff, corners_next;
  logic [2:0]  grid_row, grid_col, grid_row_eff, grid_col_eff, grid_row_next, grid_col_next;

  logic        out_free, centre_busy, fire, frame_start, in_band, done, start_centres;
  logic        lower_eff, dark, hit;
  logic [7:0]  red, green, blue;
  logic [11:0] col_inc, row_inc;
  logic signed [12:0] tl_sum, br_sum, ij_sum;
  logic [10:0] row_centre, col_centre;
  logic [31:0] pixel_res;
  logic [5:0]  cidx;
  cell_colour_t colour;
  win_req_t    win_req;
  win_stat_t   win_stat;
  row_centres_t centre_rows;
  col_centres_t centre_cols;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      detect_mode      <= 1'b0;
      frame_width      <= 11'd1280;
      frame_height     <= 11'd720;
      dark_threshold   <= 16'd0;
      white_floor      <= 8'd140;
      marker_split_row <= 11'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DETECT_MODE:      detect_mode      <= cfg_data[0];
        REG_FRAME_WIDTH:      frame_width      <= cfg_data[10:0];
        REG_FRAME_HEIGHT:     frame_height     <= cfg_data[10:0];
        REG_DARK_THRESHOLD:   dark_threshold   <= cfg_data;
        REG_WHITE_FLOOR:      white_floor      <= cfg_data[7:0];
        REG_MARKER_SPLIT_ROW: marker_split_row <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  assign out_free    = !result_valid || result_ready;
  assign fire        = s1_valid && out_free && !centre_busy;
  assign pixel_ready = !s1_valid || (out_free && !centre_busy);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pixel_valid && pixel_ready) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_valid && pixel_ready) begin
      s1_pixel <= pixel_word;
    end
  end

  always_comb begin
    red   = s1_pixel[7:0];
    green = s1_pixel[15:8];
    blue  = s1_pixel[23:16];

    frame_start = (row_count == '0) && (col_count == '0);
    in_band     = col_count >= 11'(RIGHT_BAND_START);

    // The first pixel of a frame sees the per-frame state as if freshly reset.
    if (frame_start) begin
      corners_eff  = '{NOT_FOUND_TL, NOT_FOUND_TL, NOT_FOUND_BR, NOT_FOUND_BR};
      lower_eff    = 1'b0;
      grid_row_eff = '0;
      grid_col_eff = '0;
    end else begin
      corners_eff  = corners;
      lower_eff    = lower_half;
      grid_row_eff = grid_row;
      grid_col_eff = grid_col;
    end

    win_req.clear  = fire && frame_start;
    win_req.push   = fire && !detect_mode && !in_band;
    win_req.bright = {2'd0, red} + {2'd0, green} + {2'd0, blue};

    dark   = win_stat.full && (win_stat.sum < dark_threshold);
    tl_sum = {corners_eff.top_row[11], corners_eff.top_row}
           + {corners_eff.left_col[11], corners_eff.left_col};
    br_sum = {corners_eff.bottom_row[11], corners_eff.bottom_row}
           + {corners_eff.right_col[11], corners_eff.right_col};
    ij_sum = {2'd0, row_count} + {2'd0, col_count};

    corners_next = corners_eff;
    lower_next   = lower_eff;
    pixel_res    = s1_pixel;
    if (!detect_mode) begin
      if (in_band) begin
        pixel_res = BAND_MARK_LOW;
      end else begin
        lower_next = lower_eff || (row_count > {1'b0, frame_height[10:1]});
        if (!lower_next) begin
          if (dark && (tl_sum > ij_sum)) begin
            corners_next.top_row  = {1'b0, row_count};
            corners_next.left_col = {1'b0, col_count} - 12'(WINDOW_LENGTH);
          end
        end else begin
          if (dark && (br_sum < ij_sum)) begin
            corners_next.bottom_row = {1'b0, row_count};
            corners_next.right_col  = {1'b0, col_count};
          end
        end
      end
    end else if (in_band) begin
      pixel_res = (row_count < marker_split_row) ? BAND_MARK_LOW : BAND_MARK_HIGH;
    end

    row_centre = (grid_row_eff < 3'(GRID_ROWS)) ? centre_rows[grid_row_eff] : '0;
    col_centre = centre_cols[grid_col_eff];
    hit = detect_mode && !in_band && (grid_row_eff < 3'(GRID_ROWS))
          && (grid_col_eff < 3'(GRID_COLS))
          && (row_count == row_centre) && (col_count == col_centre);

    if ((red > white_floor) && (green > white_floor)) begin
      colour = COLOUR_WHITE;
    end else if (red > green) begin
      colour = COLOUR_RED;
    end else begin
      colour = COLOUR_GREEN;
    end
    cidx = 6'({3'd0, grid_row_eff} * 6'(GRID_COLS)) + {3'd0, grid_col_eff};

    grid_row_next = grid_row_eff;
    grid_col_next = grid_col_eff;
    if (hit) begin
      if (grid_col_eff >= 3'(GRID_COLS - 1)) begin
        grid_col_next = '0;
        grid_row_next = grid_row_eff + 3'd1;
      end else begin
        grid_col_next = grid_col_eff + 3'd1;
      end
    end

    col_inc = {1'b0, col_count} + 12'd1;
    row_inc = {1'b0, row_count} + 12'd1;
    done    = 1'b0;
    if (col_inc >= {1'b0, frame_width}) begin
      col_next = '0;
      if (row_inc >= {1'b0, frame_height}) begin
        row_next = '0;
        done     = 1'b1;
      end else begin
        row_next = row_inc[10:0];
      end
    end else begin
      col_next = col_inc[10:0];
      row_next = row_count;
    end

    start_centres = fire && done && !detect_mode;
  end

  bgcd_window #(
    .WINDOW_LENGTH(WINDOW_LENGTH)
  ) u_window (
    .clk (clk),
    .rst (rst),
    .req (win_req),
    .stat(win_stat)
  );

  bgcd_centres u_centres (
    .clk        (clk),
    .rst        (rst),
    .start      (start_centres),
    .corners    (corners),
    .centre_rows(centre_rows),
    .centre_cols(centre_cols),
    .busy       (centre_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count  <= '0;
      col_count  <= '0;
      lower_half <= 1'b0;
      corners    <= '{NOT_FOUND_TL, NOT_FOUND_TL, NOT_FOUND_BR, NOT_FOUND_BR};
      grid_row   <= '0;
      grid_col   <= '0;
    end else if (fire) begin
      row_count  <= row_next;
      col_count  <= col_next;
      lower_half <= lower_next;
      corners    <= corners_next;
      grid_row   <= grid_row_next;
      grid_col   <= grid_col_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_pixel    <= pixel_res;
      frame_done   <= done;
      top_row      <= done ? corners_next.top_row[10:0] : '0;
      left_col     <= done ? corners_next.left_col : '0;
      bottom_row   <= done ? corners_next.bottom_row : '0;
      right_col    <= done ? corners_next.right_col : '0;
      colour_valid <= hit;
      cell_index   <= hit ? cidx : '0;
      cell_colour  <= hit ? colour : COLOUR_WHITE;
    end
  end

  a_cell_in_grid: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (cell_index < 6'(GRID_ROWS * GRID_COLS)))
    else $error("cell index beyond the grid");

  a_centres_hold: assert property (@(posedge clk) disable iff (rst)
    start_centres |=> centre_busy && !fire)
    else $error("pixel processed while centres were being computed");

  a_col_step: assert property (@(posedge clk) disable iff (rst)
    fire |=> (col_count == '0) || (col_count == $past(col_count) + 11'd1))
    else $error("column count skipped");

endmodule
